// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file hpfr_chk.sv.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain assertion with a fixed message.
`define CHK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Assertion with a message of the caller's choice.
`define CHK_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== rtl/core/hpfr_pkg.sv =====
package hpfr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OP_W = 2;

    // Multiplier digit width, in bits per cycle; it must divide WORD_W.
    localparam int unsigned DIGIT_W = 4;

    // Bits 31..10 of the mixed word are reduced modulo the span.
    localparam int unsigned DVD_LSB = 10;
    localparam int unsigned DVD_W = WORD_W - DVD_LSB;

    // The fraction numerator is bits 31..8 of the mixed word.
    localparam int unsigned FRAC_LSB = 8;
    localparam int unsigned FRAC_W = WORD_W - FRAC_LSB;

    localparam int unsigned ROT_L = 13;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd12345;
    localparam logic [WORD_W-1:0] HA_XOR = 32'd1057926937;
    localparam logic [WORD_W-1:0] HA_MUL = 32'd3812423987;
    localparam logic [WORD_W-1:0] HA_SQ_MUL = 32'd4000000007;
    localparam logic [WORD_W-1:0] HB_XOR = 32'd2156034509;
    localparam logic [WORD_W-1:0] HB_MUL = 32'd3699529241;

    localparam logic [OP_W-1:0] OP_FRAC = 2'd0;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd1;
    localparam logic [OP_W-1:0] OP_HASH = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x);
        rotl = (x << ROT_L) | (x >> (WORD_W - ROT_L));
    endfunction

endpackage

// ===== rtl/core/hash_prng_float_and_range_core.sv =====
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   op, hash_seed, range_low, range_high
// output    out        out_valid/out_stall value, empty_range
// config    in         start_seed_we       start_seed
//
// One request is worked on at a time. Every request but the unused op code runs the four
// serial multiplies in turn; a range or hash request then runs the bit-serial remainder
// over the 22-bit dividend unless the span is zero. An unused op code goes straight to the
// result with zeros. Reset loads the running state with 12345 and empties the output
// register. A stalled result waits in the output register while the next request runs;
// only a second finished result waits for it to drain.
module hash_prng_float_and_range_core #(
    parameter int unsigned DIGIT_W = hpfr_pkg::DIGIT_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: a write loads the running state directly.
    input  logic                          start_seed_we,
    input  logic [hpfr_pkg::WORD_W-1:0]   start_seed,
    // Request channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hpfr_pkg::OP_W-1:0]     op,
    input  logic [hpfr_pkg::WORD_W-1:0]   hash_seed,
    input  logic [hpfr_pkg::WORD_W-1:0]   range_low,
    input  logic [hpfr_pkg::WORD_W-1:0]   range_high,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hpfr_pkg::WORD_W-1:0]   value,
    output logic                          empty_range
);

    // The sequencer walks through the hash: hash A needs three products (seed xor a
    // constant times a constant, seed squared, square times constant), hash B one more.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_MUL3 = 7'b0001000,
        S_MUL4 = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;

    logic [hpfr_pkg::WORD_W-1:0] run_reg, run_next;
    logic [hpfr_pkg::OP_W-1:0]   op_reg, op_next;
    logic [hpfr_pkg::WORD_W-1:0] x_reg, x_next;
    logic [hpfr_pkg::WORD_W-1:0] lo_reg, lo_next;
    logic [hpfr_pkg::WORD_W-1:0] hi_reg, hi_next;
    logic [hpfr_pkg::WORD_W-1:0] m1_reg, m1_next;
    logic [hpfr_pkg::WORD_W-1:0] sq_reg, sq_next;
    logic [hpfr_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [hpfr_pkg::WORD_W-1:0] res_reg, res_next;
    logic                        res_empty_reg, res_empty_next;

    logic                        out_valid_reg, out_valid_next;
    logic [hpfr_pkg::WORD_W-1:0] value_reg, value_next;
    logic                        empty_reg, empty_next;

    logic [hpfr_pkg::WORD_W-1:0] mul_a, mul_b, mul_product;
    logic                        mul_start, mul_done;
    logic                        div_start, div_done;
    logic [hpfr_pkg::WORD_W-1:0] span, remainder;

    // The span wraps mod 2^32 when the upper bound is below the lower one.
    assign span = hi_reg - lo_reg;
    assign mul_start = launch_reg && (state_reg != S_DIV);
    assign div_start = launch_reg && (state_reg == S_DIV);

    hpfr_mul #(
        .DIGIT_W (DIGIT_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    hpfr_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd_reg),
        .divisor   (span),
        .done      (div_done),
        .remainder (remainder)
    );

    always_comb
    begin
        state_next = state_reg;
        launch_next = 1'b0;
        run_next = run_reg;
        op_next = op_reg;
        x_next = x_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        m1_next = m1_reg;
        sq_next = sq_reg;
        dvd_next = dvd_reg;
        res_next = res_reg;
        res_empty_next = res_empty_reg;
        out_valid_next = out_valid_reg;
        value_next = value_reg;
        empty_next = empty_reg;
        mul_a = '0;
        mul_b = '0;

        // A result taken this cycle frees the output register.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    lo_next = range_low;
                    hi_next = range_high;
                    x_next = (op == hpfr_pkg::OP_HASH) ? hash_seed : run_reg;
                    if (op == hpfr_pkg::OP_NONE)
                    begin
                        res_next = '0;
                        res_empty_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                        launch_next = 1'b1;
                    end
                end
            end
            S_MUL1:
            begin
                mul_a = x_reg ^ hpfr_pkg::HA_XOR;
                mul_b = hpfr_pkg::HA_MUL;
                if (mul_done)
                begin
                    m1_next = mul_product;
                    state_next = S_MUL2;
                    launch_next = 1'b1;
                end
            end
            S_MUL2:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
                if (mul_done)
                begin
                    sq_next = mul_product;
                    state_next = S_MUL3;
                    launch_next = 1'b1;
                end
            end
            S_MUL3:
            begin
                mul_a = sq_reg;
                mul_b = hpfr_pkg::HA_SQ_MUL;
                if (mul_done)
                begin
                    // Hash A is complete; the stateless op leaves the running state alone.
                    x_next = m1_reg ^ mul_product;
                    if (op_reg != hpfr_pkg::OP_HASH)
                    begin
                        run_next = m1_reg ^ mul_product;
                    end
                    state_next = S_MUL4;
                    launch_next = 1'b1;
                end
            end
            S_MUL4:
            begin
                mul_a = hpfr_pkg::rotl(x_reg) ^ hpfr_pkg::HB_XOR;
                mul_b = hpfr_pkg::HB_MUL;
                if (mul_done)
                begin
                    if (op_reg == hpfr_pkg::OP_FRAC)
                    begin
                        res_next = hpfr_pkg::WORD_W'(mul_product[hpfr_pkg::WORD_W-1:
                                                               hpfr_pkg::FRAC_LSB]);
                        res_empty_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (span == '0)
                    begin
                        res_next = '0;
                        res_empty_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dvd_next = mul_product[hpfr_pkg::WORD_W-1:hpfr_pkg::DVD_LSB];
                        state_next = S_DIV;
                        launch_next = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next = remainder + lo_reg;
                    res_empty_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next = res_reg;
                    empty_next = res_empty_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A seed write reloads run_reg; writes must come only while idle, not enforced.
        if (start_seed_we)
        begin
            run_next = start_seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            launch_reg <= 1'b0;
            run_reg <= hpfr_pkg::SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            launch_reg <= launch_next;
            run_reg <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        x_reg <= x_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        m1_reg <= m1_next;
        sq_reg <= sq_next;
        dvd_reg <= dvd_next;
        res_reg <= res_next;
        res_empty_reg <= res_empty_next;
        value_reg <= value_next;
        empty_reg <= empty_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign value = value_reg;
    assign empty_range = empty_reg;

endmodule

// ===== rtl/core/hpfr_mul.sv =====
// Digit-serial multiplier, product kept mod 2^WORD_W.
module hpfr_mul #(
    parameter int unsigned DIGIT_W = hpfr_pkg::DIGIT_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hpfr_pkg::WORD_W-1:0]   a,
    input  logic [hpfr_pkg::WORD_W-1:0]   b,
    output logic                          done,
    output logic [hpfr_pkg::WORD_W-1:0]   product
);

    localparam int unsigned STEPS = hpfr_pkg::WORD_W / DIGIT_W;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic [hpfr_pkg::WORD_W-1:0] a_reg, a_next;
    logic [hpfr_pkg::WORD_W-1:0] b_reg, b_next;
    logic [hpfr_pkg::WORD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [hpfr_pkg::WORD_W-1:0] partial;

    // Only the low word of each partial product reaches the result.
    assign partial = a_reg * hpfr_pkg::WORD_W'(b_reg[DIGIT_W-1:0]);

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next = a;
            b_next = b;
            acc_next = '0;
            cnt_next = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + partial;
            a_next = a_reg << DIGIT_W;
            b_next = b_reg >> DIGIT_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/core/hpfr_mod.sv =====
// Radix-2 restoring remainder, one dividend bit per cycle.
module hpfr_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hpfr_pkg::DVD_W-1:0]    dividend,
    input  logic [hpfr_pkg::WORD_W-1:0]   divisor,
    output logic                          done,
    output logic [hpfr_pkg::WORD_W-1:0]   remainder
);

    localparam int unsigned CNT_W = $clog2(hpfr_pkg::DVD_W + 1);

    logic [hpfr_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [hpfr_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [hpfr_pkg::WORD_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[hpfr_pkg::DVD_W-1]};

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(hpfr_pkg::DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so one subtract suffices.
            if (trial >= {1'b0, divisor})
            begin
                rem_next = hpfr_pkg::WORD_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[hpfr_pkg::WORD_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/hpfr_chk.sv =====
`include "assert_macros.svh"

// Port-level checks on the generator core.
module hpfr_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [hpfr_pkg::WORD_W-1:0]   value,
    input logic                          empty_range
);

    // A stalled result stays offered.
    `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

    // A stalled result keeps its payload.
    `CHK_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(value) && $stable(empty_range))

    // An empty range always comes with a zero value.
    `CHK_ASSERT_MSG(a_empty_zero, out_valid && empty_range |-> value == '0, "empty range with value")

    // Every accepted request moves the block out of idle, so the next one is held off.
    `CHK_ASSERT_MSG(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "request taken twice")

endmodule

bind hash_prng_float_and_range_core hpfr_chk u_hpfr_chk (.*);

// ===== dv/hash_prng_float_and_range_core_tb.sv =====
`timescale 1ns / 1ps

module hash_prng_float_and_range_core_tb;

    // Constants of the two hash stages. They are kept here so that the expected
    // values are derived independently of the design sources.
    localparam logic [31:0] STAGE1_XOR = 32'd1057926937;
    localparam logic [31:0] STAGE1_MUL = 32'd3812423987;
    localparam logic [31:0] STAGE1_SQ_MUL = 32'd4000000007;
    localparam logic [31:0] STAGE2_XOR = 32'd2156034509;
    localparam logic [31:0] STAGE2_MUL = 32'd3699529241;
    localparam logic [31:0] DEFAULT_SEED = 32'd12345;

    // This limit only trips when the design hangs, never in a legal run.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned N_PHASES = 6;
    localparam int unsigned ITEMS_PER_PHASE = 208;
    localparam int unsigned N_DIRECTED = 20;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int unsigned LONG_HOLD = 400;

    // One row of stimulus. Where typed is set the expected result is written
    // into the row; otherwise it comes from the generator model below.
    typedef struct {
        logic [hpfr_pkg::OP_W-1:0] opc;
        logic [31:0]     seed;
        logic [31:0]     lo;
        logic [31:0]     hi;
        bit              typed;
        logic [31:0]     want_value;
        logic            want_empty;
    } req_row_t;

    typedef struct packed {
        logic [31:0] num;
        logic        empty_flag;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start_seed_we;
    logic [31:0]        start_seed;
    logic               in_valid;
    logic               in_stall;
    logic [hpfr_pkg::OP_W-1:0] op;
    logic [31:0]        hash_seed;
    logic [31:0]        range_low;
    logic [31:0]        range_high;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        value;
    logic               empty_range;

    // Model copy of the seed register and of the running generator state.
    logic [31:0]        seed_copy;
    logic [31:0]        gen_state;

    // Results still owed by the block, oldest first.
    outcome_t           pending_results[$];

    int unsigned        errors = 0;
    int unsigned        cycle_count = 0;
    int unsigned        hold_requests = 0;
    bit                 tx_burst = 1'b0;

    int unsigned        n_frac = 0;
    int unsigned        n_range = 0;
    int unsigned        n_hash = 0;
    int unsigned        n_unused = 0;
    int unsigned        n_seed_loads = 0;
    int unsigned        n_empty_seen = 0;

    // Directed rows: extremes of the bounds and seeds, every op, the zero
    // span, wrapped spans, a span of one, and the unused op code.
    req_row_t directed_rows [N_DIRECTED] = '{
        // First fraction after reset, then one with the range fields at their maximum.
        '{hpfr_pkg::OP_FRAC,  32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 1'b0},
        '{hpfr_pkg::OP_FRAC,  32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 1'b0},
        // Widest unwrapped span.
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'h00000000, 32'hffffffff, 1'b0, 32'h0, 1'b0},
        // Zero spans force 0 and raise the flag, while the state still advances.
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h0, 1'b1},
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'hffffffff, 32'hffffffff, 1'b1, 32'h0, 1'b1},
        // A span of one always returns the lower bound, also when it wraps.
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'h00000005, 32'h00000006, 1'b1, 32'h5, 1'b0},
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b1,
          32'hffffffff, 1'b0},
        // Wrapped spans, where the upper bound lies below the lower one.
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'hf0000000, 32'h00001000, 1'b0, 32'h0, 1'b0},
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'h80000000, 32'h7fffffff, 1'b0, 32'h0, 1'b0},
        // Stateless hashes of the extreme seeds, a zero span, a span of one, a wrapped span.
        '{hpfr_pkg::OP_HASH,  32'h00000000, 32'h00000000, 32'hffffffff, 1'b0, 32'h0, 1'b0},
        '{hpfr_pkg::OP_HASH,  32'hffffffff, 32'h00000000, 32'hffffffff, 1'b0, 32'h0, 1'b0},
        '{hpfr_pkg::OP_HASH,  32'h000004d2, 32'h00000007, 32'h00000007, 1'b1, 32'h0, 1'b1},
        '{hpfr_pkg::OP_HASH,  32'ha5a5a5a5, 32'h0000000a, 32'h0000000b, 1'b1, 32'ha, 1'b0},
        '{hpfr_pkg::OP_HASH,  32'h5a5a5a5a, 32'hffffff00, 32'h00000100, 1'b0, 32'h0, 1'b0},
        // The unused op code returns zeros and leaves the state alone.
        '{hpfr_pkg::OP_NONE,  32'hffffffff, 32'h00000001, 32'h00000002, 1'b1, 32'h0, 1'b0},
        '{hpfr_pkg::OP_NONE,  32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h0, 1'b0},
        '{hpfr_pkg::OP_FRAC,  32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 1'b0},
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'h00000000, 32'h00000001, 1'b1, 32'h0, 1'b0},
        // A span of 2^22 passes the whole dividend through unchanged.
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'h00000064, 32'h00400064, 1'b0, 32'h0, 1'b0},
        '{hpfr_pkg::OP_RANGE, 32'h00000000, 32'h00000000, 32'h00000003, 1'b0, 32'h0, 1'b0}
    };

    hash_prng_float_and_range_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_seed_we (start_seed_we),
        .start_seed    (start_seed),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .hash_seed     (hash_seed),
        .range_low     (range_low),
        .range_high    (range_high),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .empty_range   (empty_range)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // First stage: xor-multiply, xored with a scaled square, all modulo 2^32.
    function automatic logic [31:0] scramble_state(input logic [31:0] x);
        logic [31:0] sq;
        sq = x * x;
        return ((x ^ STAGE1_XOR) * STAGE1_MUL) ^ (sq * STAGE1_SQ_MUL);
    endfunction

    // Second stage: rotate left by 13, then xor-multiply.
    function automatic logic [31:0] finish_word(input logic [31:0] x);
        logic [31:0] rot;
        rot = {x[18:0], x[31:19]};
        return (rot ^ STAGE2_XOR) * STAGE2_MUL;
    endfunction

    // Bits 31..10 of the mixed word modulo the wrapped span, plus the low bound.
    function automatic void fold_into_range(input logic [31:0] word, input logic [31:0] lo,
                                            input logic [31:0] hi, output logic [31:0] res,
                                            output logic empty);
        logic [31:0] span;
        span = hi - lo;
        if (span == 32'd0)
        begin
            res = 32'd0;
            empty = 1'b1;
        end
        else
        begin
            res = ((word >> 10) % span) + lo;
            empty = 1'b0;
        end
    endfunction

    // Expected result of one request; advances gen_state for ops 0 and 1.
    function automatic void predict_request(input req_row_t r, output logic [31:0] res,
                                            output logic empty);
        logic [31:0] mixed;
        res = 32'd0;
        empty = 1'b0;
        case (r.opc)
            hpfr_pkg::OP_FRAC:
            begin
                gen_state = scramble_state(gen_state);
                mixed = finish_word(gen_state);
                res = {8'd0, mixed[31:8]};
            end
            hpfr_pkg::OP_RANGE:
            begin
                gen_state = scramble_state(gen_state);
                fold_into_range(finish_word(gen_state), r.lo, r.hi, res, empty);
            end
            hpfr_pkg::OP_HASH:
                fold_into_range(finish_word(scramble_state(r.seed)), r.lo, r.hi, res, empty);
            default:
            begin
                res = 32'd0;
                empty = 1'b0;
            end
        endcase
    endfunction

    // Most idle stretches are short, about one in ten is long.
    function automatic int unsigned pick_idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    // Offers one request and waits until it is taken. Valid stays high from one
    // request to the next when there is no gap, so it is never lowered and raised
    // in the same step. The expectation is recorded at the accepting edge.
    task automatic offer_request(input req_row_t r);
        int unsigned gap;
        logic [31:0] res;
        logic        empty;
        gap = 0;
        if (!tx_burst && $urandom_range(0, 1) == 1)
            gap = pick_idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= r.opc;
        hash_seed  <= r.seed;
        range_low  <= r.lo;
        range_high <= r.hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(r, res, empty);
        if (r.typed)
            pending_results.push_back('{num: r.want_value, empty_flag: r.want_empty});
        else
            pending_results.push_back('{num: res, empty_flag: empty});
        case (r.opc)
            hpfr_pkg::OP_FRAC: n_frac++;
            hpfr_pkg::OP_RANGE: n_range++;
            hpfr_pkg::OP_HASH: n_hash++;
            default: n_unused++;
        endcase
    endtask

    // Stops offering and waits until every owed result has been taken. The
    // queue is looked at on the falling edge, away from the checker's updates.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Receiver side. It alternates between quiet stretches and stretches with
    // random stalls, and serves a long hold-off whenever the stimulus asks for one.
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_seen;
        int unsigned rx_cycles;
        bit          rx_quiet;
        stall_left = 0;
        hold_seen = 0;
        rx_cycles = 0;
        rx_quiet = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles % 200 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left == 0 && !rx_quiet && $urandom_range(0, 99) < 30)
                stall_left = pick_idle_len();
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker: every taken result is compared with the oldest one owed.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (empty_range)
                n_empty_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual value %h empty_range %b",
                         $time, value, empty_range);
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.num)
                begin
                    errors++;
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, want.num, value);
                end
                if (empty_range !== want.empty_flag)
                begin
                    errors++;
                    $display("%0t: empty_range mismatch: expected %b, actual %b",
                             $time, want.empty_flag, empty_range);
                end
            end
        end
    end

    // Watchdog against a hung design.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Main sequence. Phase 0 runs from the reset seed with the directed rows in
    // front; every later phase first reloads the seed register while the block
    // is idle, with the extreme seeds among the values.
    initial
    begin
        logic [31:0] phase_seeds [N_PHASES];
        rst_n = 1'b0;
        start_seed_we = 1'b0;
        start_seed = 32'd0;
        in_valid = 1'b0;
        op = hpfr_pkg::OP_FRAC;
        hash_seed = 32'd0;
        range_low = 32'd0;
        range_high = 32'd0;
        seed_copy = DEFAULT_SEED;
        gen_state = DEFAULT_SEED;
        phase_seeds[0] = DEFAULT_SEED;
        phase_seeds[1] = 32'h00000000;
        phase_seeds[2] = 32'hffffffff;
        phase_seeds[3] = $urandom;
        phase_seeds[4] = $urandom;
        phase_seeds[5] = 32'h00000001;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                drain_results();
                start_seed_we <= 1'b1;
                start_seed    <= phase_seeds[ph];
                seed_copy = phase_seeds[ph];
                gen_state = seed_copy;
                n_seed_loads++;
                @(posedge clk);
                start_seed_we <= 1'b0;
                @(posedge clk);
            end

            if (ph == 0)
            begin
                tx_burst = 1'b0;
                for (int i = 0; i < N_DIRECTED; i++)
                    offer_request(directed_rows[i]);
            end

            // In one phase the receiver holds off for a long stretch while
            // requests keep coming back to back, so the block backs up.
            if (ph == 2)
                hold_requests <= hold_requests + 1;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                req_row_t r;
                int unsigned pick;
                if (ph == 2 && i < 60)
                    tx_burst = 1'b1;
                else if (i % 64 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);

                pick = $urandom_range(0, 99);
                if (pick < 30)
                    r.opc = hpfr_pkg::OP_FRAC;
                else if (pick < 65)
                    r.opc = hpfr_pkg::OP_RANGE;
                else if (pick < 95)
                    r.opc = hpfr_pkg::OP_HASH;
                else
                    r.opc = hpfr_pkg::OP_NONE;
                r.seed = $urandom;
                r.lo = $urandom;
                // Bounds: arbitrary pairs, short spans, zero spans, nearly full
                // wrapped spans, extreme corners and spans of every magnitude.
                case ($urandom_range(0, 5))
                    0: r.hi = $urandom;
                    1: r.hi = r.lo + $urandom_range(1, 300);
                    2: r.hi = r.lo;
                    3: r.hi = r.lo - $urandom_range(1, 1000);
                    4:
                    begin
                        r.lo = ($urandom_range(0, 1) == 1) ? 32'hffffffff : 32'h00000000;
                        r.hi = ($urandom_range(0, 1) == 1) ? 32'hffffffff : 32'h00000000;
                    end
                    default: r.hi = r.lo + ($urandom >> $urandom_range(0, 31));
                endcase
                r.typed = 1'b0;
                r.want_value = 32'd0;
                r.want_empty = 1'b0;
                offer_request(r);
            end
        end

        drain_results();
        // Any result that shows up now has nothing owed and is flagged.
        repeat (100) @(posedge clk);

        $display("Ran %0d requests: %0d fraction, %0d range, %0d hashed, %0d unused op.",
                 n_frac + n_range + n_hash + n_unused, n_frac, n_range, n_hash, n_unused);
        $display("Seed loads: %0d, empty-range results: %0d, errors: %0d.",
                 n_seed_loads, n_empty_seen, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hpfr_pkg.sv
rtl/core/hpfr_mul.sv
rtl/core/hpfr_mod.sv
rtl/core/hash_prng_float_and_range_core.sv
rtl/core/hpfr_chk.sv
dv/hash_prng_float_and_range_core_tb.sv
